FILE: rtl/pps_pkg.sv
// ----------------------------------------------------------------------------
// pps_pkg
// types and constants shared by the priority scheduler files
// ----------------------------------------------------------------------------
package pps_pkg;

  localparam int unsigned MAX_PROCS = 16;
  localparam int unsigned IDX_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int unsigned CNT_W     = $clog2(MAX_PROCS + 1);
  localparam int unsigned PIDX_W    = 4;
  localparam int unsigned TIME_W    = 32;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef enum logic [1:0] {
    ST_LOADED   = 2'd0,
    ST_REJECTED = 2'd1,
    ST_RAN      = 2'd2,
    ST_IDLE     = 2'd3
  } status_e;

  typedef struct packed {
    logic        kind;
    logic [15:0] arrival_time;
    logic [15:0] burst_length;
    logic [7:0]  priority_level;
  } in_item_t;

  typedef struct packed {
    status_e             status;
    logic [PIDX_W-1:0]   proc_index;
    logic                finished;
    logic [TIME_W-1:0]   finish_time;
    logic [TIME_W-1:0]   turnaround;
    logic [TIME_W-1:0]   waiting;
    logic                all_done;
  } out_item_t;

  // one table entry as stored in the process memory
  typedef struct packed {
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [7:0]  prio;
    logic [15:0] remaining;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

FILE: rtl/pps_ram.sv
// ----------------------------------------------------------------------------
// pps_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module pps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/preemptive_priority_scheduler.sv
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler
// preemptive priority scheduler over a table of up to MAX_PROCS processes
// ----------------------------------------------------------------------------
// usage:
//   input channel in_valid_i / in_stall_o / in_data_i carries load or tick
//   items; output channel out_valid_o / out_stall_i / out_data_o returns one
//   result item for every input item, in order.
//   a load item writes one entry into the process ram, or is rejected on a
//   full table; its result goes through the emit state into the output
//   register and the next item is taken back in idle. a tick on an empty
//   table takes the same path. any other tick scans the loaded entries
//   through the single read port of the ram, one entry per cycle, writes
//   the picked entry back in the finish state, then passes a wait state for
//   the waiting time subtract when the picked process finishes, and emits.
//   one item is in work at a time; the next item is taken while the last
//   result still sits in the output register.
//   reset clears the counters and the time; the ram itself is not cleared,
//   only entries below the load count are ever used.
//   when the receiver stalls, the result holds in the output register and a
//   later finished result waits in the emit state until the register frees.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler
  import pps_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  // sequencer states, one-hot
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_FIN  = 5'b00100,
    S_WAIT = 5'b01000,
    S_EMIT = 5'b10000
  } state_e;

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    load_cnt_q, load_cnt_d;
  logic [CNT_W-1:0]    comp_cnt_q, comp_cnt_d;
  logic [TIME_W-1:0]   time_q, time_d;
  logic [TIME_W-1:0]   ftime_q, ftime_d;
  logic                out_valid_q, out_valid_d;
  out_item_t           out_q, out_d;

  // scan bookkeeping
  logic [IDX_W-1:0]    chk_q, chk_d;
  logic                found_q, found_d;
  logic [IDX_W-1:0]    pick_q, pick_d;
  entry_t              best_q, best_d;
  logic [TIME_W-1:0]   tat_q, tat_d;
  out_item_t           res_q, res_d;

  // ram port signals
  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  entry_t              ram_wdata;
  logic [IDX_W-1:0]    ram_raddr;
  logic [ENTRY_W-1:0]  ram_rdata;
  entry_t              rd_entry;

  logic                in_acc;
  logic                out_free;
  logic                full;
  logic                ready_ent;
  logic                better;
  logic                last_ent;
  logic [TIME_W-1:0]   next_time;

  pps_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_PROCS)
  ) u_proc_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_entry   = entry_t'(ram_rdata);
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && (state_q == S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign full       = (load_cnt_q == CNT_W'(MAX_PROCS));
  assign next_time  = (time_q == '1) ? time_q : time_q + TIME_W'(1);

  // entry under inspection: arrived, unfinished, strictly more urgent
  assign ready_ent = (TIME_W'(rd_entry.arrival) <= time_q) && (rd_entry.remaining != '0);
  assign better    = !found_q || (rd_entry.prio < best_q.prio);
  assign last_ent  = (CNT_W'(chk_q) + CNT_W'(1)) == load_cnt_q;

  always_comb begin
    state_d     = state_q;
    load_cnt_d  = load_cnt_q;
    comp_cnt_d  = comp_cnt_q;
    time_d      = time_q;
    ftime_d     = ftime_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    chk_d       = chk_q;
    found_d     = found_q;
    pick_d      = pick_q;
    best_d      = best_q;
    tat_d       = tat_q;
    res_d       = res_q;

    ram_we      = 1'b0;
    ram_waddr   = pick_q;
    ram_wdata   = best_q;
    ram_raddr   = chk_q + IDX_W'(1);

    // the output register drains on its own
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        ram_raddr = '0;
        if (in_acc) begin
          res_d = '0;
          if (in_data_i.kind == KIND_LOAD) begin
            if (full) begin
              res_d.status = ST_REJECTED;
            end else begin
              ram_we                = 1'b1;
              ram_waddr             = load_cnt_q[IDX_W-1:0];
              ram_wdata.arrival     = in_data_i.arrival_time;
              ram_wdata.burst       = in_data_i.burst_length;
              ram_wdata.prio        = in_data_i.priority_level;
              ram_wdata.remaining   = in_data_i.burst_length;
              load_cnt_d            = load_cnt_q + CNT_W'(1);
              // zero burst counts as done at load
              if (in_data_i.burst_length == '0) begin
                comp_cnt_d = comp_cnt_q + CNT_W'(1);
              end
              res_d.status     = ST_LOADED;
              res_d.proc_index = PIDX_W'(load_cnt_q[IDX_W-1:0]);
            end
            state_d = S_EMIT;
          end else begin
            ftime_d = next_time;
            found_d = 1'b0;
            chk_d   = '0;
            if (load_cnt_q == '0) begin
              res_d.status = ST_IDLE;
              time_d       = next_time;
              state_d      = S_EMIT;
            end else begin
              state_d = S_SCAN;
            end
          end
        end
      end

      S_SCAN: begin
        if (ready_ent && better) begin
          found_d = 1'b1;
          pick_d  = chk_q;
          best_d  = rd_entry;
        end
        chk_d = chk_q + IDX_W'(1);
        if (last_ent) begin
          state_d = S_FIN;
        end
      end

      S_FIN: begin
        time_d = ftime_q;
        if (!found_q) begin
          res_d.status = ST_IDLE;
          state_d      = S_EMIT;
        end else begin
          ram_we              = 1'b1;
          ram_wdata.remaining = best_q.remaining - 16'd1;
          res_d.status        = ST_RAN;
          res_d.proc_index    = PIDX_W'(pick_q);
          if (best_q.remaining == 16'd1) begin
            comp_cnt_d        = comp_cnt_q + CNT_W'(1);
            res_d.finished    = 1'b1;
            res_d.finish_time = ftime_q;
            tat_d             = ftime_q - TIME_W'(best_q.arrival);
            state_d           = S_WAIT;
          end else begin
            state_d = S_EMIT;
          end
        end
      end

      S_WAIT: begin
        res_d.turnaround = tat_q;
        res_d.waiting    = (tat_q >= TIME_W'(best_q.burst)) ?
                           tat_q - TIME_W'(best_q.burst) : '0;
        state_d          = S_EMIT;
      end

      S_EMIT: begin
        if (out_free) begin
          out_d          = res_q;
          out_d.all_done = (comp_cnt_q == load_cnt_q);
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      load_cnt_q  <= '0;
      comp_cnt_q  <= '0;
      time_q      <= '0;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
      chk_q       <= '0;
    end else begin
      state_q     <= state_d;
      load_cnt_q  <= load_cnt_d;
      comp_cnt_q  <= comp_cnt_d;
      time_q      <= time_d;
      out_valid_q <= out_valid_d;
      found_q     <= found_d;
      chk_q       <= chk_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    ftime_q <= ftime_d;
    out_q   <= out_d;
    pick_q  <= pick_d;
    best_q  <= best_d;
    tat_q   <= tat_d;
    res_q   <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  a_comp_le_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    comp_cnt_q <= load_cnt_q)
    else $error("completed count above loaded count");

  a_load_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_cnt_q <= CNT_W'(MAX_PROCS))
    else $error("loaded count beyond table size");

  a_time_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> time_q >= $past(time_q))
    else $error("time went backwards");

  a_wait_le_tat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.finished) |-> (out_q.waiting <= out_q.turnaround))
    else $error("waiting time above turnaround");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the preemptive priority scheduler: a directed
// opening (empty table, ties, preemption, zero burst, late arrival), then
// random load and tick items, with random idling on both channels, one long
// receiver hold-off and a quiet tail
// ----------------------------------------------------------------------------
import pps_pkg::*;

// mirror of the process table; predicts one report per accepted item and
// checks the reports that come back in order
class sched_tracker;
  logic [15:0] arrival_tab [MAX_PROCS];
  logic [15:0] burst_tab   [MAX_PROCS];
  logic [7:0]  prio_tab    [MAX_PROCS];
  logic [15:0] left_tab    [MAX_PROCS];
  int unsigned n_loaded;
  int unsigned n_done;
  logic [31:0] clock_now;
  out_item_t   pending_reports[$];
  int unsigned mismatches;
  int unsigned reports_seen;
  int unsigned n_load_ok, n_reject, n_run, n_finish, n_idle;

  function new();
    n_loaded = 0;
    n_done = 0;
    clock_now = '0;
    mismatches = 0;
    reports_seen = 0;
    n_load_ok = 0;
    n_reject = 0;
    n_run = 0;
    n_finish = 0;
    n_idle = 0;
  endfunction

  function void accept_item(in_item_t it);
    out_item_t   r;
    int          pick;
    logic [7:0]  best;
    logic [31:0] t0;
    r = '0;
    best = '0;
    if (it.kind == KIND_LOAD) begin
      if (n_loaded >= MAX_PROCS) begin
        r.status = ST_REJECTED;
        n_reject++;
      end else begin
        arrival_tab[n_loaded] = it.arrival_time;
        burst_tab[n_loaded]   = it.burst_length;
        prio_tab[n_loaded]    = it.priority_level;
        left_tab[n_loaded]    = it.burst_length;
        r.status     = ST_LOADED;
        r.proc_index = n_loaded[PIDX_W-1:0];
        n_loaded++;
        // zero burst is complete from the start
        if (it.burst_length == 16'd0) n_done++;
        n_load_ok++;
      end
    end else begin
      // most urgent ready process, first one wins on a tie
      pick = -1;
      for (int i = 0; i < n_loaded; i++) begin
        if ({16'd0, arrival_tab[i]} <= clock_now && left_tab[i] != 16'd0 &&
            (pick < 0 || prio_tab[i] < best)) begin
          pick = i;
          best = prio_tab[i];
        end
      end
      t0 = clock_now;
      if (clock_now != '1) clock_now++;
      if (pick < 0) begin
        r.status = ST_IDLE;
        n_idle++;
      end else begin
        left_tab[pick] = left_tab[pick] - 16'd1;
        r.status     = ST_RAN;
        r.proc_index = pick[PIDX_W-1:0];
        n_run++;
        if (left_tab[pick] == 16'd0) begin
          n_done++;
          n_finish++;
          r.finished    = 1'b1;
          r.finish_time = (t0 == '1) ? '1 : t0 + 32'd1;
          r.turnaround  = r.finish_time - {16'd0, arrival_tab[pick]};
          r.waiting     = (r.turnaround >= {16'd0, burst_tab[pick]}) ?
                          r.turnaround - {16'd0, burst_tab[pick]} : '0;
        end
      end
    end
    r.all_done = (n_done == n_loaded);
    pending_reports.push_back(r);
  endfunction

  function void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: report %0d %s mismatch, expected %0d, actual %0d",
               $time, reports_seen, what, want, got);
      mismatches++;
    end
  endfunction

  function void compare_report(out_item_t got);
    out_item_t want;
    if (pending_reports.size() == 0) begin
      $display("%0t: report with none expected, expected nothing, actual %h",
               $time, got);
      mismatches++;
    end else begin
      want = pending_reports.pop_front();
      check_field("status", 32'(want.status), 32'(got.status));
      check_field("proc_index", 32'(want.proc_index), 32'(got.proc_index));
      check_field("finished", 32'(want.finished), 32'(got.finished));
      check_field("finish_time", want.finish_time, got.finish_time);
      check_field("turnaround", want.turnaround, got.turnaround);
      check_field("waiting", want.waiting, got.waiting);
      check_field("all_done", 32'(want.all_done), 32'(got.all_done));
    end
    reports_seen++;
  endfunction
endclass

module tb_top;

  localparam int unsigned RANDOM_ITEMS = 1685;
  localparam int unsigned QUIET_TAIL   = 150;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned HOLD_AT      = 300;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 40;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;

  sched_tracker board;
  int unsigned  cycle_count = 0;
  bit           tail_phase = 1'b0;   // no idling on either side once set
  bit           hold_done = 1'b0;

  always #2 clk_i = ~clk_i;

  preemptive_priority_scheduler dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // both channels are sampled at the edge; handshake values are pre-edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) board.accept_item(in_data_i);
      if (out_valid_o && !out_stall_i) board.compare_report(out_data_o);
    end
  end

  // hard stop in case the block hangs
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d reports still expected",
               cycle_count, board.pending_reports.size());
      $display("simulation failed");
      $finish;
    end
  end

  // present one item and hold it until taken; valid stays high afterwards
  task automatic offer(in_item_t it);
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
  endtask

  task automatic pause_sender(int unsigned n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  function automatic in_item_t load_item(logic [15:0] arr, logic [15:0] burst,
                                         logic [7:0] prio);
    in_item_t it;
    it.kind           = KIND_LOAD;
    it.arrival_time   = arr;
    it.burst_length   = burst;
    it.priority_level = prio;
    return it;
  endfunction

  // tick items carry junk in the unused fields
  function automatic in_item_t tick_item();
    in_item_t it;
    it.kind           = KIND_TICK;
    it.arrival_time   = 16'($urandom);
    it.burst_length   = 16'($urandom);
    it.priority_level = 8'($urandom);
    return it;
  endfunction

  // receiver: random stall bursts, calm stretches, one long hold-off
  initial begin
    bit busy_mode;
    busy_mode = 1'b1;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (!hold_done && board.reports_seen >= HOLD_AT) begin
        // long hold so the result register and the work slot both fill up
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_done = 1'b1;
      end else if (!tail_phase && busy_mode && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end
      if ($urandom_range(0, 199) == 0) busy_mode = !busy_mode;
    end
  end

  initial begin
    in_item_t    it;
    int unsigned loads_sent;
    int unsigned roll;
    bit          gappy;
    board = new();
    gappy = 1'b1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table: idle tick, all_done already set
    offer(tick_item());
    // slot 0 least urgent, slot 1 most urgent
    offer(load_item(16'd0, 16'd3, 8'd255));
    offer(load_item(16'd0, 16'd2, 8'd0));
    // zero burst, done at load, never picked
    offer(load_item(16'hFFFF, 16'd0, 8'd128));
    // arrives at time 2, ties with slot 1, then preempts slot 0
    offer(load_item(16'd2, 16'd1, 8'd0));
    // ties, finishes, preemption, slot 0 to completion, then idle
    repeat (9) offer(tick_item());
    loads_sent = 4;

    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      tail_phase = (n >= RANDOM_ITEMS - QUIET_TAIL);
      if (!tail_phase) begin
        if ($urandom_range(0, 99) == 0) gappy = !gappy;
        if (gappy && $urandom_range(0, 2) == 0) pause_sender($urandom_range(1, 12));
      end
      it = tick_item();
      // mostly ticks; a load now and then, late ones land on a full table
      if (n % 90 == 45 || $urandom_range(0, 199) == 0) begin
        it.kind = KIND_LOAD;
        if (loads_sent == MAX_PROCS - 1) begin
          // last slot: never arrives within the run, every bit high
          it.arrival_time = 16'hFFFF;
          it.burst_length = 16'hFFFF;
        end else if (loads_sent < MAX_PROCS - 1) begin
          if ($urandom_range(0, 4) == 0)
            it.arrival_time = 16'($urandom_range(0, board.clock_now));
          else
            it.arrival_time = 16'(board.clock_now + $urandom_range(0, 60));
          roll = $urandom_range(0, 9);
          if (roll == 0)     it.burst_length = 16'd0;
          else if (roll < 4) it.burst_length = 16'($urandom_range(31, 400));
          else               it.burst_length = 16'($urandom_range(1, 30));
        end
        loads_sent++;
      end
      offer(it);
    end
    in_valid_i <= 1'b0;

    while (board.pending_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d reports: %0d loads, %0d rejected loads, %0d idle ticks",
             board.reports_seen, board.n_load_ok, board.n_reject, board.n_idle);
    $display("  %0d run ticks with %0d completions, one long receiver hold-off",
             board.n_run, board.n_finish);
    if (board.mismatches == 0 && board.pending_reports.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: preemptive_priority_scheduler.f
rtl/pps_pkg.sv
rtl/pps_ram.sv
rtl/preemptive_priority_scheduler.sv
tb/tb_top.sv
